[rtl/bsk_pkg.sv]
// bsk_pkg: shared constants, command and state codes, and the store request struct
// for the msb-first bit stack; used by the interfaces and all rtl modules
// no dependencies
package bsk_pkg;

   // store geometry
   localparam int STORE_BYTES = 64;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int BYTE_W      = 8;

   // field widths
   localparam int CMD_W   = 3;
   localparam int IDX_W   = 9;
   localparam int SLICE_W = 4;
   localparam int APP_W   = 4;
   localparam int COUNT_W = 10;
   localparam int CAP_W   = 7;

   // capacity register after reset, in bytes
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_BIT   = 3'd0,
      CMD_PUSH_SLICE = 3'd1,
      CMD_POP        = 3'd2,
      CMD_GET        = 3'd3,
      CMD_SET        = 3'd4,
      CMD_CLEAR      = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BYTE_A,
      ST_BYTE_B,
      ST_HOLD
   } state_type;

   // one request into the byte store: read, write and clear-all
   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic              clear_all;
   } mem_req_type;

endpackage

[rtl/bsk_if.sv]
// bsk_req_if and bsk_rsp_if: valid/ready channels for commands and results
// depends on bsk_pkg
interface bsk_req_if;
   import bsk_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic               bit_value;
   logic [IDX_W-1:0]   bit_index;
   logic [BYTE_W-1:0]  byte_value;
   logic [SLICE_W-1:0] slice_from;
   logic [SLICE_W-1:0] slice_to;

   modport source (
      output valid, command, bit_value, bit_index, byte_value, slice_from, slice_to,
      input  ready
   );
   modport sink (
      input  valid, command, bit_value, bit_index, byte_value, slice_from, slice_to,
      output ready
   );
endinterface

interface bsk_rsp_if;
   import bsk_pkg::*;

   logic               valid;
   logic               ready;
   logic               bit_out;
   logic               failed;
   logic [APP_W-1:0]   bits_appended;
   logic [COUNT_W-1:0] fill_count;

   modport source (
      output valid, bit_out, failed, bits_appended, fill_count,
      input  ready
   );
   modport sink (
      input  valid, bit_out, failed, bits_appended, fill_count,
      output ready
   );
endinterface

[rtl/bsk_store.sv]
// bsk_store: byte memory with registered read and per-byte valid bits
// depends on bsk_pkg (geometry and mem_req_type)
module bsk_store (
   input  logic                        clock,
   input  logic                        reset,
   input  bsk_pkg::mem_req_type        mem_req,
   output logic [bsk_pkg::BYTE_W-1:0]  rd_data
);
   import bsk_pkg::*;

   logic [BYTE_W-1:0]      bytes_mem [STORE_BYTES];
   logic [BYTE_W-1:0]      rd_data_ff;
   logic                   rd_valid_ff;
   logic [STORE_BYTES-1:0] valid_ff;

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         bytes_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= bytes_mem[mem_req.rd_addr];
      end
   end

   // valid bits: a byte never written since reset or clear reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_req.rd_en) begin
            rd_valid_ff <= valid_ff[mem_req.rd_addr] && !mem_req.clear_all;
         end
         if (mem_req.clear_all) begin
            valid_ff <= '0;
         end else if (mem_req.wr_en) begin
            valid_ff[mem_req.wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

[rtl/bsk_seq.sv]
// bsk_seq: command decode, fill count, read-modify-write sequencer and result register
// depends on bsk_pkg and bsk_if; drives the byte store through mem_req_type
module bsk_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [bsk_pkg::CAP_W-1:0]   cap_bytes,
   bsk_req_if.sink                     req_bus,
   bsk_rsp_if.source                   rsp_bus,
   output bsk_pkg::mem_req_type        mem_req,
   input  logic [bsk_pkg::BYTE_W-1:0]  rd_data
);
   import bsk_pkg::*;

   state_type state_ff, state_in;

   logic [COUNT_W-1:0] count_ff, count_in;

   // per-command operation latched at the transfer
   logic [ADDR_W-1:0] addr_a_ff, addr_b_ff;
   logic [BYTE_W-1:0] or_a_ff, or_b_ff, clr_a_ff;
   logic              we_a_ff, need_b_ff, want_bit_ff;
   logic [2:0]        sel_ff;
   logic              failed_ff;
   logic [APP_W-1:0]  app_ff;
   logic              res_bit_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_bit_ff;
   logic               rsp_failed_ff;
   logic [APP_W-1:0]   rsp_app_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   // decode results
   logic [ADDR_W-1:0]  dec_addr_a, dec_addr_b;
   logic [BYTE_W-1:0]  dec_or_a, dec_or_b, dec_clr_a;
   logic               dec_we_a, dec_need_b, dec_want_bit, dec_clear;
   logic [2:0]         dec_sel;
   logic               dec_failed;
   logic [APP_W-1:0]   dec_app;

   // helpers
   logic [CAP_W-1:0]   cap_sat;
   logic [COUNT_W-1:0] cap_bits;
   logic [COUNT_W-1:0] last_pos;
   logic [COUNT_W-1:0] idx_ext;
   logic [COUNT_W-1:0] room;
   logic [SLICE_W-1:0] slice_hi, slice_n, slice_k;
   logic [BYTE_W-1:0]  slice_bits;
   logic [2*BYTE_W-1:0] slice_win;
   logic               accept, out_free, finish, bit_a;

   assign accept   = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign bit_a    = want_bit_ff && rd_data[3'd7 - sel_ff];

   // capacity in bits, saturated to the store size
   assign cap_sat  = (cap_bytes > CAP_W'(STORE_BYTES)) ? CAP_W'(STORE_BYTES) : cap_bytes;
   assign cap_bits = COUNT_W'({cap_sat, 3'b000});
   assign last_pos = count_ff - COUNT_W'(1);
   assign idx_ext  = COUNT_W'(req_bus.bit_index);

   // slice: bits pushed, aligned to the msb and then to the fill position
   always_comb begin
      slice_hi   = (req_bus.slice_to > SLICE_W'(BYTE_W)) ? SLICE_W'(BYTE_W) : req_bus.slice_to;
      slice_n    = (req_bus.slice_from < slice_hi) ? (slice_hi - req_bus.slice_from) : '0;
      room       = (count_ff < cap_bits) ? (cap_bits - count_ff) : '0;
      slice_k    = (room < COUNT_W'(slice_n)) ? room[SLICE_W-1:0] : slice_n;
      slice_bits = (req_bus.byte_value << req_bus.slice_from[2:0])
                   & ~(8'hFF >> slice_k);
      slice_win  = {slice_bits, 8'h00} >> count_ff[2:0];
   end

   // command decode against the current fill count
   always_comb begin
      dec_addr_a   = count_ff[ADDR_W+2:3];
      dec_addr_b   = count_ff[ADDR_W+2:3] + ADDR_W'(1);
      dec_or_a     = '0;
      dec_or_b     = '0;
      dec_clr_a    = '0;
      dec_we_a     = 1'b0;
      dec_need_b   = 1'b0;
      dec_want_bit = 1'b0;
      dec_clear    = 1'b0;
      dec_sel      = '0;
      dec_failed   = 1'b0;
      dec_app      = '0;
      count_in     = count_ff;
      unique case (req_bus.command)
         CMD_PUSH_BIT: begin
            if (count_ff < cap_bits) begin
               dec_or_a = req_bus.bit_value ? (8'h80 >> count_ff[2:0]) : 8'h00;
               dec_we_a = 1'b1;
               dec_app  = APP_W'(1);
               count_in = count_ff + COUNT_W'(1);
            end else begin
               dec_failed = 1'b1;
            end
         end
         CMD_PUSH_SLICE: begin
            dec_or_a   = slice_win[2*BYTE_W-1:BYTE_W];
            dec_or_b   = slice_win[BYTE_W-1:0];
            dec_we_a   = (slice_k != '0);
            dec_need_b = (slice_win[BYTE_W-1:0] != '0);
            dec_app    = slice_k;
            dec_failed = (slice_k < slice_n);
            count_in   = count_ff + COUNT_W'(slice_k);
         end
         CMD_POP: begin
            if (count_ff == '0) begin
               dec_failed = 1'b1;
            end else begin
               dec_addr_a   = last_pos[ADDR_W+2:3];
               dec_clr_a    = 8'h80 >> last_pos[2:0];
               dec_sel      = last_pos[2:0];
               dec_want_bit = 1'b1;
               dec_we_a     = 1'b1;
               count_in     = last_pos;
            end
         end
         CMD_GET: begin
            dec_addr_a = req_bus.bit_index[ADDR_W+2:3];
            dec_sel    = req_bus.bit_index[2:0];
            if (idx_ext < count_ff) begin
               dec_want_bit = 1'b1;
            end else begin
               dec_failed = 1'b1;
            end
         end
         CMD_SET: begin
            dec_addr_a = req_bus.bit_index[ADDR_W+2:3];
            if (idx_ext < cap_bits) begin
               dec_or_a = req_bus.bit_value ? (8'h80 >> req_bus.bit_index[2:0]) : 8'h00;
               dec_we_a = 1'b1;
               if (count_ff < idx_ext + COUNT_W'(1)) begin
                  count_in = idx_ext + COUNT_W'(1);
               end
            end else begin
               dec_failed = 1'b1;
            end
         end
         CMD_CLEAR: begin
            dec_clear = 1'b1;
            count_in  = '0;
         end
         default: begin
         end
      endcase
   end

   // sequencer: next state, store traffic and result hand-off
   always_comb begin
      state_in          = state_ff;
      req_bus.ready     = 1'b0;
      mem_req           = '0;
      finish            = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_bus.ready     = 1'b1;
            mem_req.rd_en     = accept && !dec_clear;
            mem_req.rd_addr   = dec_addr_a;
            mem_req.clear_all = accept && dec_clear;
            if (accept) begin
               state_in = ST_BYTE_A;
            end
         end
         ST_BYTE_A: begin
            mem_req.wr_en   = we_a_ff;
            mem_req.wr_addr = addr_a_ff;
            mem_req.wr_data = (rd_data | or_a_ff) & ~clr_a_ff;
            mem_req.rd_en   = need_b_ff;
            mem_req.rd_addr = addr_b_ff;
            if (need_b_ff) begin
               state_in = ST_BYTE_B;
            end else begin
               finish   = 1'b1;
               state_in = out_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_BYTE_B: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = addr_b_ff;
            mem_req.wr_data = rd_data | or_b_ff;
            finish          = 1'b1;
            state_in        = out_free ? ST_IDLE : ST_HOLD;
         end
         ST_HOLD: begin
            finish   = 1'b1;
            state_in = out_free ? ST_IDLE : ST_HOLD;
         end
      endcase
   end

   assign rsp_valid_in = (finish && out_free) || (rsp_valid_ff && !rsp_bus.ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // operation latched at the transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         addr_a_ff   <= dec_addr_a;
         addr_b_ff   <= dec_addr_b;
         or_a_ff     <= dec_or_a;
         or_b_ff     <= dec_or_b;
         clr_a_ff    <= dec_clr_a;
         we_a_ff     <= dec_we_a;
         need_b_ff   <= dec_need_b;
         want_bit_ff <= dec_want_bit;
         sel_ff      <= dec_sel;
         failed_ff   <= dec_failed;
         app_ff      <= dec_app;
      end
      if (state_ff == ST_BYTE_A) begin
         res_bit_ff <= bit_a;
      end
   end

   // result register, loaded when the previous result has been taken
   always_ff @(posedge clock) begin
      if (finish && out_free) begin
         rsp_bit_ff    <= (state_ff == ST_BYTE_A) ? bit_a : res_bit_ff;
         rsp_failed_ff <= failed_ff;
         rsp_app_ff    <= app_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.bit_out       = rsp_bit_ff;
   assign rsp_bus.failed        = rsp_failed_ff;
   assign rsp_bus.bits_appended = rsp_app_ff;
   assign rsp_bus.fill_count    = rsp_count_ff;

   // fill count never passes the store size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(STORE_BYTES * BYTE_W))
      else $error("fill count above store size");

   // a transfer always starts the first store access
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_BYTE_A)
      else $error("transfer did not start a store access");

   // holding a result only happens while the output is occupied
   a_hold_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HOLD |-> rsp_valid_ff)
      else $error("result held with an empty output register");

   // no same-byte read and write in one cycle
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_req.wr_en && mem_req.rd_en) |-> mem_req.wr_addr != mem_req.rd_addr)
      else $error("read and write to the same byte in one cycle");

endmodule

[rtl/msb_first_bit_stack_core.sv]
// msb_first_bit_stack_core: top level of the msb-first packed bit stack
// depends on bsk_pkg, bsk_if, bsk_store and bsk_seq
//
// Usage:
//  - req_bus carries one command per transfer (push bit, push byte slice, pop,
//    get, set, clear); rsp_bus returns exactly one result per command, in order
//  - csr_wr_en / csr_wr_data write the capacity in bytes; write only while idle
//  - bits live in a 64 x 8 memory with a registered read; a command
//    reads the byte it touches and writes it back when it changes it
//  - a new command is taken only once the previous one is done; a byte slice
//    that crosses a byte boundary needs a second read-modify-write on the
//    single memory port; the result is loaded into the output register when
//    ST_BYTE_A ends, or ST_BYTE_B for a crossing slice
//  - when the receiver stalls, the finished result waits in the output
//    register; the next command is still taken and parks its result in the
//    sequencer (ST_HOLD), and the input stalls until the output register frees
//  - reset (synchronous, active high) empties the stack at once through
//    per-byte valid bits and sets the capacity to 64 bytes; clear works the
//    same way in a single command
module msb_first_bit_stack_core (
   input  logic                        clock,
   input  logic                        reset,
   bsk_req_if.sink                     req_bus,
   bsk_rsp_if.source                   rsp_bus,
   input  logic                        csr_wr_en,
   input  logic [bsk_pkg::CAP_W-1:0]   csr_wr_data
);
   import bsk_pkg::*;

   logic [CAP_W-1:0]  cap_ff;
   mem_req_type       mem_req;
   logic [BYTE_W-1:0] rd_data;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   bsk_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cap_bytes (cap_ff),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

   bsk_store u_store (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// tb: self-checking testbench for msb_first_bit_stack_core, with a driver, a monitor and
// a bit-accurate stack predictor; depends on bsk_pkg, bsk_if and the core rtl
module tb;
   import bsk_pkg::*;

   // unused command codes, the block must answer them without any change
   localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

   localparam int RESET_CYCLES     = 10;
   localparam int DRAIN_CYCLES     = 6;
   localparam int HOLD_CYCLES      = 300;
   localparam int NUM_PHASES       = 8;
   localparam int RANDOM_PER_PHASE = 110;
   localparam int LONG_HOLD_PHASE  = 6;
   localparam int RUN_LIMIT        = 200000;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic               bit_value;
      logic [IDX_W-1:0]   bit_index;
      logic [BYTE_W-1:0]  byte_value;
      logic [SLICE_W-1:0] slice_from;
      logic [SLICE_W-1:0] slice_to;
   } stack_cmd_type;

   typedef struct packed {
      logic               bit_out;
      logic               failed;
      logic [APP_W-1:0]   bits_appended;
      logic [COUNT_W-1:0] fill_count;
   } stack_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;

   bsk_req_if req_bus ();
   bsk_rsp_if rsp_bus ();

   msb_first_bit_stack_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow copy of the stack state and the capacity register
   logic [BYTE_W-1:0]  shadow_bytes [STORE_BYTES];
   logic [COUNT_W-1:0] shadow_fill;
   logic [CAP_W-1:0]   shadow_cap;

   stack_cmd_type    pending_cmds [$];
   stack_result_type expected_results [$];
   stack_cmd_type    held_cmd;

   int          send_idle_pct;
   int          recv_idle_pct;
   logic        long_hold_pending;
   int          hold_left;
   int          error_count;
   int unsigned cycle_count = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // stack predictor
   // ---------------------------------------------------------------------

   function automatic int unsigned capacity_bits();
      return ((shadow_cap > STORE_BYTES) ? STORE_BYTES : shadow_cap) * 8;
   endfunction

   // append one bit at the top, msb first within each byte
   function automatic logic push_shadow_bit(input logic v);
      if (shadow_fill >= capacity_bits()) return 1'b0;
      shadow_bytes[shadow_fill[8:3]][~shadow_fill[2:0]] =
         shadow_bytes[shadow_fill[8:3]][~shadow_fill[2:0]] | v;
      shadow_fill = shadow_fill + 1'b1;
      return 1'b1;
   endfunction

   function automatic stack_result_type apply_stack_command(input stack_cmd_type c);
      stack_result_type r;
      logic [IDX_W-1:0] last;
      r = '0;
      case (c.command)
         CMD_PUSH_BIT: begin
            if (push_shadow_bit(c.bit_value)) r.bits_appended = APP_W'(1);
            else r.failed = 1'b1;
         end
         CMD_PUSH_SLICE: begin
            // positions past 7 never push, even inside the slice
            for (int p = 0; p < 8; p++) begin
               if (p >= c.slice_from && p < c.slice_to) begin
                  if (push_shadow_bit(c.byte_value[7-p]))
                     r.bits_appended = r.bits_appended + APP_W'(1);
                  else r.failed = 1'b1;
               end
            end
         end
         CMD_POP: begin
            if (shadow_fill == 0) begin
               r.failed = 1'b1;
            end else begin
               last = IDX_W'(shadow_fill - 1'b1);
               r.bit_out = shadow_bytes[last[8:3]][~last[2:0]];
               shadow_bytes[last[8:3]][~last[2:0]] = 1'b0;
               shadow_fill = shadow_fill - 1'b1;
            end
         end
         CMD_GET: begin
            if (c.bit_index >= shadow_fill) r.failed = 1'b1;
            else r.bit_out = shadow_bytes[c.bit_index[8:3]][~c.bit_index[2:0]];
         end
         CMD_SET: begin
            // or-in only, and the count grows to cover the index
            if (c.bit_index >= capacity_bits()) begin
               r.failed = 1'b1;
            end else begin
               shadow_bytes[c.bit_index[8:3]][~c.bit_index[2:0]] =
                  shadow_bytes[c.bit_index[8:3]][~c.bit_index[2:0]] | c.bit_value;
               if (shadow_fill < c.bit_index + 1) shadow_fill = COUNT_W'(c.bit_index + 1);
            end
         end
         CMD_CLEAR: begin
            foreach (shadow_bytes[i]) shadow_bytes[i] = '0;
            shadow_fill = '0;
         end
         default: begin
         end
      endcase
      r.fill_count = shadow_fill;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int bval,
                            input int idx, input logic [BYTE_W-1:0] bval8,
                            input int from, input int upto);
      stack_cmd_type c;
      c.command    = cmd;
      c.bit_value  = 1'(bval);
      c.bit_index  = IDX_W'(idx);
      c.byte_value = bval8;
      c.slice_from = SLICE_W'(from);
      c.slice_to   = SLICE_W'(upto);
      pending_cmds.push_back(c);
   endtask

   function automatic stack_cmd_type random_cmd();
      stack_cmd_type c;
      int unsigned   pick;
      int unsigned   top_index;
      pick      = $urandom_range(0, 99);
      top_index = (capacity_bits() == 0) ? 0 : capacity_bits() - 1;
      if (pick < 26) c.command = CMD_PUSH_BIT;
      else if (pick < 50) c.command = CMD_PUSH_SLICE;
      else if (pick < 64) c.command = CMD_POP;
      else if (pick < 80) c.command = CMD_GET;
      else if (pick < 92) c.command = CMD_SET;
      else if (pick < 95) c.command = CMD_CLEAR;
      else if (pick < 97) c.command = CMD_SPARE_A;
      else c.command = CMD_SPARE_B;
      c.bit_value  = 1'($urandom_range(0, 1));
      // mostly inside the capacity, sometimes anywhere
      c.bit_index  = IDX_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, top_index)
                                                       : $urandom_range(0, 511));
      c.byte_value = BYTE_W'($urandom_range(0, 255));
      c.slice_from = SLICE_W'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 8)
                                                          : $urandom_range(0, 15));
      c.slice_to   = SLICE_W'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 8)
                                                          : $urandom_range(0, 15));
      return c;
   endfunction

   function automatic logic [CAP_W-1:0] phase_capacity(input int ph);
      case (ph)
         0:       return 7'd127;
         1:       return 7'd3;
         2:       return 7'd0;
         3:       return 7'd1;
         4:       return 7'd64;
         5:       return 7'd40;
         6:       return 7'd17;
         default: return 7'd64;
      endcase
   endfunction

   // block is idle once every command is taken and every result is back
   task automatic wait_until_drained();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || req_bus.valid || expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shadow_cap = value;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // command driver
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      stack_cmd_type next_cmd;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         // predict at the transfer, in transfer order
         if (req_bus.valid && req_bus.ready)
            expected_results.push_back(apply_stack_command(held_cmd));
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_cmd = pending_cmds.pop_front();
               held_cmd           <= next_cmd;
               req_bus.valid      <= 1'b1;
               req_bus.command    <= next_cmd.command;
               req_bus.bit_value  <= next_cmd.bit_value;
               req_bus.bit_index  <= next_cmd.bit_index;
               req_bus.byte_value <= next_cmd.byte_value;
               req_bus.slice_from <= next_cmd.slice_from;
               req_bus.slice_to   <= next_cmd.slice_to;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // result receiver, with one long hold-off on request
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (long_hold_pending) begin
         long_hold_pending = 1'b0;
         rsp_bus.ready <= 1'b0;
         hold_left     <= HOLD_CYCLES;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // result monitor
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      stack_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with no command outstanding");
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.bit_out !== want.bit_out) begin
               $error("bit_out expected %0d got %0d", want.bit_out, rsp_bus.bit_out);
               error_count++;
            end
            if (rsp_bus.failed !== want.failed) begin
               $error("failed expected %0d got %0d", want.failed, rsp_bus.failed);
               error_count++;
            end
            if (rsp_bus.bits_appended !== want.bits_appended) begin
               $error("bits_appended expected %0d got %0d",
                      want.bits_appended, rsp_bus.bits_appended);
               error_count++;
            end
            if (rsp_bus.fill_count !== want.fill_count) begin
               $error("fill_count expected %0d got %0d", want.fill_count, rsp_bus.fill_count);
               error_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // sequence of phases
   // ---------------------------------------------------------------------

   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_bus.valid      = 1'b0;
      req_bus.command    = '0;
      req_bus.bit_value  = 1'b0;
      req_bus.bit_index  = '0;
      req_bus.byte_value = '0;
      req_bus.slice_from = '0;
      req_bus.slice_to   = '0;
      rsp_bus.ready      = 1'b0;
      held_cmd           = '0;
      long_hold_pending  = 1'b0;
      error_count        = 0;
      send_idle_pct      = 23;
      recv_idle_pct      = 62;
      foreach (shadow_bytes[i]) shadow_bytes[i] = '0;
      shadow_fill = '0;
      shadow_cap  = CAP_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty stack, slice edges, full store, spare codes, clear
      queue_cmd(CMD_POP,        0,   0, 8'h00, 0,  0);
      queue_cmd(CMD_GET,        0,   0, 8'h00, 0,  0);
      queue_cmd(CMD_PUSH_BIT,   1,   0, 8'h00, 0,  0);
      queue_cmd(CMD_PUSH_BIT,   0,   0, 8'h00, 0,  0);
      queue_cmd(CMD_PUSH_SLICE, 0,   0, 8'hA5, 0,  8);
      queue_cmd(CMD_PUSH_SLICE, 0,   0, 8'hFF, 3,  3);
      queue_cmd(CMD_PUSH_SLICE, 0,   0, 8'hFF, 6,  12);
      queue_cmd(CMD_PUSH_SLICE, 0,   0, 8'hFF, 9,  15);
      queue_cmd(CMD_PUSH_SLICE, 0,   0, 8'hFF, 5,  2);
      queue_cmd(CMD_PUSH_SLICE, 0,   0, 8'h00, 0,  15);
      queue_cmd(CMD_GET,        0,   0, 8'h00, 0,  0);
      queue_cmd(CMD_GET,        0,  19, 8'h00, 0,  0);
      queue_cmd(CMD_GET,        0,  20, 8'h00, 0,  0);
      queue_cmd(CMD_SET,        1, 511, 8'h00, 0,  0);
      queue_cmd(CMD_SET,        0, 200, 8'h00, 0,  0);
      queue_cmd(CMD_SET,        1,   0, 8'h00, 0,  0);
      queue_cmd(CMD_PUSH_BIT,   1,   0, 8'h00, 0,  0);
      queue_cmd(CMD_PUSH_SLICE, 0,   0, 8'hFF, 0,  8);
      queue_cmd(CMD_GET,        0, 511, 8'h00, 0,  0);
      queue_cmd(CMD_POP,        0,   0, 8'h00, 0,  0);
      queue_cmd(CMD_POP,        0,   0, 8'h00, 0,  0);
      // two slots left, so the slice runs out of room halfway
      queue_cmd(CMD_PUSH_SLICE, 0,   0, 8'hFF, 0,  4);
      queue_cmd(CMD_SPARE_A,    1, 511, 8'hFF, 15, 15);
      queue_cmd(CMD_SPARE_B,    1, 511, 8'hFF, 15, 15);
      queue_cmd(CMD_CLEAR,      0,   0, 8'h00, 0,  0);
      queue_cmd(CMD_POP,        0,   0, 8'h00, 0,  0);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_until_drained();
         write_capacity(phase_capacity(ph));
         if (ph < 3) begin
            send_idle_pct = 23;
            recv_idle_pct = 62;
         end else if (ph < 6) begin
            send_idle_pct = 62;
            recv_idle_pct = 23;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (ph == LONG_HOLD_PHASE) long_hold_pending = 1'b1;
         repeat (RANDOM_PER_PHASE) pending_cmds.push_back(random_cmd());
         // leave the stack full so the next, smaller capacity sits below the count
         if (ph == 0) queue_cmd(CMD_SET, 1, 511, 8'h00, 0, 0);
      end

      wait_until_drained();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
